>>> hw/rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg: alarm clock controller shared definitions
// Types, register indexes, key codes and the BCD helper functions used by the
// alarm clock controller modules.
// ----------------------------------------------------------------------------
package acc_pkg;

    localparam int DigitW  = 4;
    localparam int ThrW    = 10;
    localparam int PeriodW = 16;
    localparam int KeyW    = 4;
    localparam int SegW    = 7;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;

    typedef logic [DigitW-1:0] digit_t;
    // Digit 0 is seconds ones, digit 5 is hours tens.
    typedef digit_t [5:0] bcd_time_t;
    typedef logic [1:0] field_t;
    typedef logic [SegW-1:0] seg_t;

    localparam logic [CfgIdxW-1:0] REG_SHUTOFF = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_BLINK   = 2'd1;

    localparam logic [KeyW-1:0] KEY_MODE  = 4'd1;
    localparam logic [KeyW-1:0] KEY_FIELD = 4'd2;
    localparam logic [KeyW-1:0] KEY_DOWN  = 4'd4;
    localparam logic [KeyW-1:0] KEY_UP    = 4'd8;

    localparam field_t FIELD_NONE = 2'd0;
    localparam field_t FIELD_SEC  = 2'd1;
    localparam field_t FIELD_MIN  = 2'd2;
    localparam field_t FIELD_HR   = 2'd3;

    localparam logic [ThrW-1:0]    THR_RESET    = 10'd50;
    localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd50000;
    localparam bcd_time_t CLOCK_RESET = {4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
    localparam bcd_time_t ALARM_RESET = {4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd5};

    localparam seg_t SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct packed {
        logic            second_tick;
        logic [KeyW-1:0] keys;
        logic [ThrW-1:0] force_req;
    } in_item_t;

    typedef struct packed {
        bcd_time_t shown;
        logic      led;
        logic      alarm_on;
    } step_result_t;

    typedef struct packed {
        seg_t seg_sec_ones;
        seg_t seg_sec_tens;
        seg_t seg_min_ones;
        seg_t seg_min_tens;
        seg_t seg_hr_ones;
        seg_t seg_hr_tens;
        logic led;
        logic alarm_on;
    } out_item_t;

    function automatic seg_t seg_decode(digit_t d);
        return SEG_TABLE[d];
    endfunction

    // One-second advance of the 24-hour time; 23:59:59 wraps to 00:00:00.
    function automatic bcd_time_t bcd_advance(bcd_time_t d);
        bcd_time_t r;
        r = d;
        r[0] = r[0] + 4'd1;
        if (r[0] == 4'd10)
        begin
            r[0] = 4'd0;
            r[1] = r[1] + 4'd1;
        end
        if (r[1] == 4'd6)
        begin
            r[1] = 4'd0;
            r[2] = r[2] + 4'd1;
        end
        if (r[2] == 4'd10)
        begin
            r[2] = 4'd0;
            r[3] = r[3] + 4'd1;
        end
        if (r[3] == 4'd6)
        begin
            r[3] = 4'd0;
            r[4] = r[4] + 4'd1;
        end
        if (r[4] == 4'd10 || (r[4] == 4'd4 && r[5] == 4'd2))
        begin
            r[4] = 4'd0;
            r[5] = r[5] + 4'd1;
        end
        if (r[5] == 4'd3)
        begin
            r[5] = 4'd0;
        end
        return r;
    endfunction

    // Increment of one two-digit field; returns {tens, ones}.
    function automatic logic [2*DigitW-1:0] field_up(digit_t ones, digit_t tens,
                                                      logic hours);
        digit_t o0;
        digit_t o1;
        o0 = ones + 4'd1;
        o1 = tens;
        if (hours)
        begin
            if (o0 == 4'd10 || (o0 == 4'd4 && o1 == 4'd2))
            begin
                o0 = 4'd0;
                o1 = o1 + 4'd1;
            end
            if (o1 == 4'd3)
            begin
                o1 = 4'd0;
            end
        end
        else
        begin
            if (o0 == 4'd10)
            begin
                o0 = 4'd0;
                o1 = o1 + 4'd1;
            end
            if (o1 == 4'd6)
            begin
                o1 = 4'd0;
            end
        end
        return {o1, o0};
    endfunction

    // Decrement of one two-digit field; returns {tens, ones}.
    function automatic logic [2*DigitW-1:0] field_down(digit_t ones, digit_t tens,
                                                        logic hours);
        digit_t o0;
        digit_t o1;
        o0 = ones;
        o1 = tens;
        if (o0 != 4'd0)
        begin
            o0 = o0 - 4'd1;
        end
        else if (o1 != 4'd0)
        begin
            o0 = 4'd9;
            o1 = o1 - 4'd1;
        end
        else if (hours)
        begin
            o0 = 4'd3;
            o1 = 4'd2;
        end
        else
        begin
            o0 = 4'd9;
            o1 = 4'd5;
        end
        return {o1, o0};
    endfunction

endpackage

>>> hw/rtl/acc_if.sv
// ----------------------------------------------------------------------------
// acc_if: alarm clock controller channel interfaces
// Valid/ready channels for poll steps, display results and register writes.
// ----------------------------------------------------------------------------
interface acc_in_if;
    import acc_pkg::*;

    logic                valid;
    logic                ready;
    logic                second_tick;
    logic [KeyW-1:0]     keys;
    logic [ThrW-1:0]     force_req;

    modport source (output valid, second_tick, keys, force_req, input ready);
    modport sink (input valid, second_tick, keys, force_req, output ready);
endinterface

interface acc_out_if;
    import acc_pkg::*;

    logic valid;
    logic ready;
    seg_t seg_sec_ones;
    seg_t seg_sec_tens;
    seg_t seg_min_ones;
    seg_t seg_min_tens;
    seg_t seg_hr_ones;
    seg_t seg_hr_tens;
    logic led;
    logic alarm_on;

    modport source (output valid, seg_sec_ones, seg_sec_tens, seg_min_ones,
                    seg_min_tens, seg_hr_ones, seg_hr_tens, led, alarm_on,
                    input ready);
    modport sink (input valid, seg_sec_ones, seg_sec_tens, seg_min_ones,
                  seg_min_tens, seg_hr_ones, seg_hr_tens, led, alarm_on,
                  output ready);
endinterface

interface acc_cfg_if;
    import acc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

>>> hw/rtl/acc_in_stage.sv
// ----------------------------------------------------------------------------
// acc_in_stage: input register
// Holds one accepted poll step until the step logic consumes it.
// ----------------------------------------------------------------------------
module acc_in_stage
    import acc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     out_free,
    output logic     fire,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign fire     = valid_reg && out_free;
    assign in_ready = !valid_reg || out_free;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hw/rtl/acc_step.sv
// ----------------------------------------------------------------------------
// acc_step: clock, alarm and key state
// Applies one poll step to the time, alarm, blink and key state and returns
// the digits to show together with the LED and alarm flags.
// ----------------------------------------------------------------------------
module acc_step
    import acc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  in_item_t           item,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    output step_result_t       result
);

    logic [ThrW-1:0]    thr_reg;
    logic [PeriodW-1:0] period_reg;
    bcd_time_t          clock_reg;
    bcd_time_t          clock_next;
    bcd_time_t          alarm_reg;
    bcd_time_t          alarm_next;
    logic               set_mode_reg;
    logic               set_mode_next;
    field_t             field_reg;
    field_t             field_next;
    logic               latched_reg;
    logic               latched_next;
    logic               phase_reg;
    logic               phase_next;
    logic               led_reg;
    logic               led_next;
    logic [PeriodW-1:0] count_reg;
    logic [PeriodW-1:0] count_next;
    logic               held_reg;
    logic               held_next;
    logic               is_key;
    logic [2*DigitW-1:0] pair_old;
    logic [2*DigitW-1:0] pair_new;

    always_comb
    begin
        clock_next    = clock_reg;
        alarm_next    = alarm_reg;
        set_mode_next = set_mode_reg;
        field_next    = field_reg;
        latched_next  = latched_reg;
        phase_next    = phase_reg;
        led_next      = led_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        pair_old      = '0;
        pair_new      = '0;

        if (item.second_tick)
        begin
            clock_next = bcd_advance(clock_reg);
            if (clock_next == alarm_reg)
            begin
                latched_next = 1'b1;
            end
        end

        if (latched_next)
        begin
            count_next = count_reg + 16'd1;
            if (count_next == period_reg)
            begin
                count_next = '0;
                phase_next = !phase_reg;
                led_next   = !phase_reg;
            end
            if (item.force_req >= thr_reg)
            begin
                latched_next = 1'b0;
                led_next     = 1'b0;
            end
        end

        case (field_reg)
            FIELD_SEC: pair_old = {alarm_reg[1], alarm_reg[0]};
            FIELD_MIN: pair_old = {alarm_reg[3], alarm_reg[2]};
            FIELD_HR:  pair_old = {alarm_reg[5], alarm_reg[4]};
            default:   pair_old = '0;
        endcase
        if (item.keys == KEY_DOWN)
        begin
            pair_new = field_down(pair_old[DigitW-1:0], pair_old[2*DigitW-1:DigitW],
                                  field_reg == FIELD_HR);
        end
        else
        begin
            pair_new = field_up(pair_old[DigitW-1:0], pair_old[2*DigitW-1:DigitW],
                                field_reg == FIELD_HR);
        end

        if (!held_reg)
        begin
            if (item.keys == KEY_MODE)
            begin
                held_next     = 1'b1;
                set_mode_next = !set_mode_reg;
                if (!set_mode_reg)
                begin
                    field_next = FIELD_SEC;
                end
            end
            else if (item.keys == KEY_FIELD)
            begin
                held_next = 1'b1;
                case (field_reg)
                    FIELD_SEC: field_next = FIELD_MIN;
                    FIELD_MIN: field_next = FIELD_HR;
                    FIELD_HR:  field_next = FIELD_SEC;
                    default:   field_next = field_reg;
                endcase
            end
            else if ((item.keys == KEY_DOWN || item.keys == KEY_UP) && set_mode_reg)
            begin
                held_next = 1'b1;
                case (field_reg)
                    FIELD_SEC: {alarm_next[1], alarm_next[0]} = pair_new;
                    FIELD_MIN: {alarm_next[3], alarm_next[2]} = pair_new;
                    FIELD_HR:  {alarm_next[5], alarm_next[4]} = pair_new;
                    default:   alarm_next = alarm_reg;
                endcase
            end
        end

        is_key = item.keys == KEY_MODE || item.keys == KEY_FIELD ||
                 item.keys == KEY_DOWN || item.keys == KEY_UP;
        if (!is_key)
        begin
            held_next = 1'b0;
        end
    end

    assign result.shown    = set_mode_next ? alarm_next : clock_next;
    assign result.led      = led_next;
    assign result.alarm_on = latched_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg    <= CLOCK_RESET;
            alarm_reg    <= ALARM_RESET;
            set_mode_reg <= 1'b0;
            field_reg    <= FIELD_SEC;
            latched_reg  <= 1'b0;
            phase_reg    <= 1'b0;
            led_reg      <= 1'b0;
            count_reg    <= '0;
            held_reg     <= 1'b0;
        end
        else if (fire)
        begin
            clock_reg    <= clock_next;
            alarm_reg    <= alarm_next;
            set_mode_reg <= set_mode_next;
            field_reg    <= field_next;
            latched_reg  <= latched_next;
            phase_reg    <= phase_next;
            led_reg      <= led_next;
            count_reg    <= count_next;
            held_reg     <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHUTOFF: thr_reg    <= cfg_wdata[ThrW-1:0];
                REG_BLINK:   period_reg <= cfg_wdata[PeriodW-1:0];
                default:     ;
            endcase
        end
    end

endmodule

>>> hw/rtl/acc_out_stage.sv
// ----------------------------------------------------------------------------
// acc_out_stage: display decode and result register
// Turns the shown digits into segment patterns and holds the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module acc_out_stage
    import acc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  step_result_t result,
    input  logic         out_ready,
    output logic         out_valid,
    output logic         free,
    output out_item_t    out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.seg_sec_ones <= seg_decode(result.shown[0]);
            item_reg.seg_sec_tens <= seg_decode(result.shown[1]);
            item_reg.seg_min_ones <= seg_decode(result.shown[2]);
            item_reg.seg_min_tens <= seg_decode(result.shown[3]);
            item_reg.seg_hr_ones  <= seg_decode(result.shown[4]);
            item_reg.seg_hr_tens  <= seg_decode(result.shown[5]);
            item_reg.led          <= result.led;
            item_reg.alarm_on     <= result.alarm_on;
        end
    end

endmodule

>>> hw/rtl/bcd_alarm_clock_controller.sv
// ----------------------------------------------------------------------------
// bcd_alarm_clock_controller: 24-hour BCD alarm clock
// Top level joining the input register, the step logic and the result
// register.
// ----------------------------------------------------------------------------
// Each transaction on in_ch is one poll step: a one-second tick, the raw key
// value and a force reading. For every step one result leaves on out_ch:
// six seven-segment patterns (clock time, or alarm time in set mode), the
// LED drive and the alarm flag, all after that step's update.
// The step is held in the input register and its result in the result
// register, from which out_ch.valid rises. One step is accepted per cycle
// while the receiver keeps taking results; the step logic is a single
// combinational pass between the input register and the result register.
// cfg_ch writes the shutoff threshold (index 0) and the blink period
// (index 1); it is always ready, and other indexes are ignored. Write it
// only while no step is in flight.
// Reset sets the time to 00:00:00, the alarm to 00:00:15, both registers to
// their defaults and empties both stages. When the receiver stalls, the
// result register holds, one more step waits in the input register, and
// in_ch.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_controller
    import acc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    acc_in_if.sink   in_ch,
    acc_out_if.source out_ch,
    acc_cfg_if.sink  cfg_ch
);

    in_item_t     in_item;
    in_item_t     item;
    logic         fire;
    logic         out_free;
    step_result_t result;
    out_item_t    out_item;

    assign in_item.second_tick = in_ch.second_tick;
    assign in_item.keys        = in_ch.keys;
    assign in_item.force_req   = in_ch.force_req;

    assign cfg_ch.ready = 1'b1;

    acc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_item  (in_item),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    acc_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cfg_we    (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_wdata (cfg_ch.wdata),
        .result    (result)
    );

    acc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .free      (out_free),
        .out_item  (out_item)
    );

    assign out_ch.seg_sec_ones = out_item.seg_sec_ones;
    assign out_ch.seg_sec_tens = out_item.seg_sec_tens;
    assign out_ch.seg_min_ones = out_item.seg_min_ones;
    assign out_ch.seg_min_tens = out_item.seg_min_tens;
    assign out_ch.seg_hr_ones  = out_item.seg_hr_ones;
    assign out_ch.seg_hr_tens  = out_item.seg_hr_tens;
    assign out_ch.led          = out_item.led;
    assign out_ch.alarm_on     = out_item.alarm_on;

endmodule

>>> hw/rtl/acc_checker.sv
// ----------------------------------------------------------------------------
// acc_checker: port-level checks for the alarm clock controller
// Watches the top-level channels and flags behavior the design must not show.
// ----------------------------------------------------------------------------
module acc_checker
    import acc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input seg_t seg_min_tens,
    input seg_t seg_hr_tens,
    input logic led,
    input logic alarm_on
);

    // A stalled result must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seg_hr_tens) && $stable(led))
    else $error("stalled result changed");

    // With the result register empty, the input side can never be blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked while output empty");

    // The LED is only lit while the alarm is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !alarm_on |-> !led)
    else $error("LED lit without active alarm");

    // Hours tens shows 0, 1 or 2 and minutes tens shows 0 to 5.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (seg_hr_tens == SEG_TABLE[0] || seg_hr_tens == SEG_TABLE[1] ||
                       seg_hr_tens == SEG_TABLE[2]) &&
                      (seg_min_tens == SEG_TABLE[0] || seg_min_tens == SEG_TABLE[1] ||
                       seg_min_tens == SEG_TABLE[2] || seg_min_tens == SEG_TABLE[3] ||
                       seg_min_tens == SEG_TABLE[4] || seg_min_tens == SEG_TABLE[5]))
    else $error("tens digit out of range");

endmodule

bind bcd_alarm_clock_controller acc_checker u_acc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .seg_min_tens (out_ch.seg_min_tens),
    .seg_hr_tens  (out_ch.seg_hr_tens),
    .led          (out_ch.led),
    .alarm_on     (out_ch.alarm_on)
);

>>> sim/bcd_alarm_clock_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_alarm_clock_controller_tb: self-checking bench for the BCD alarm clock
// Drives poll steps through the valid/ready input channel, predicts the
// display, LED and alarm flag of every step and compares each result
// transaction against it. A short table of directed steps comes first. Then
// random rounds follow: each one keys the alarm to a few seconds ahead of the
// clock and then polls with random ticks, keys and force readings. A final
// round ticks every step with the alarm held on and the longest blink period,
// then releases it with full force.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_controller_tb;
    import acc_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
    localparam logic [KeyW-1:0]    KEYS_IDLE  = 4'd0;
    localparam int DAY_SECS = 86400;
    localparam int FINAL_STEPS = 150;

    localparam out_item_t VIEW_RESET = '{7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F,
                                         1'b0, 1'b0};
    localparam out_item_t VIEW_FIRST_TICK = '{7'h06, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F,
                                              1'b0, 1'b0};
    localparam out_item_t VIEW_ALARM_RESET = '{7'h6D, 7'h06, 7'h3F, 7'h3F, 7'h3F, 7'h3F,
                                               1'b0, 1'b0};

    typedef struct packed {
        in_item_t  step;
        logic      typed;
        out_item_t view;
    } row_t;

    // Key handling walk: set mode, held keys, chords, field cycling and the
    // hour wrap of the alarm's hour field.
    localparam row_t DIRECTED_ROWS [26] = '{
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b1, VIEW_RESET},
        '{in_item_t'{1'b1, KEYS_IDLE, 10'd1023}, 1'b1, VIEW_FIRST_TICK},
        '{in_item_t'{1'b0, KEY_MODE, 10'd1023},  1'b1, VIEW_ALARM_RESET},
        '{in_item_t'{1'b0, KEY_MODE, 10'd0},     1'b0, '0},
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEY_DOWN, 10'd512},   1'b0, '0},
        '{in_item_t'{1'b0, KEY_FIELD, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEY_FIELD, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, 4'd6, 10'd0},         1'b0, '0},
        '{in_item_t'{1'b0, KEY_DOWN, 10'd0},     1'b0, '0},
        '{in_item_t'{1'b0, 4'd15, 10'd0},        1'b0, '0},
        '{in_item_t'{1'b0, KEY_FIELD, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEY_DOWN, 10'd0},     1'b0, '0},
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEY_UP, 10'd0},       1'b0, '0},
        '{in_item_t'{1'b0, 4'd9, 10'd0},         1'b0, '0},
        '{in_item_t'{1'b0, KEY_MODE, 10'd0},     1'b0, '0},
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEY_UP, 10'd0},       1'b0, '0},
        '{in_item_t'{1'b0, KEY_MODE, 10'd0},     1'b0, '0},
        '{in_item_t'{1'b0, KEYS_IDLE, 10'd0},    1'b0, '0},
        '{in_item_t'{1'b0, KEY_UP, 10'd0},       1'b0, '0},
        '{in_item_t'{1'b1, KEYS_IDLE, 10'd341},  1'b0, '0},
        '{in_item_t'{1'b0, KEY_MODE, 10'd682},   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    acc_in_if  in_ch ();
    acc_out_if out_ch ();
    acc_cfg_if cfg_ch ();

    assign out_ch.ready = sink_ready;

    bcd_alarm_clock_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #6 clk = ~clk;

    // Predicted state of the clock.
    bcd_time_t          clk_time;
    bcd_time_t          alm_time;
    logic               setting;
    field_t             fsel;
    logic               alm_latched;
    logic               blink_ph;
    logic               led_on;
    logic [PeriodW-1:0] blink_cnt;
    logic               held;
    logic [ThrW-1:0]    thr;
    logic [PeriodW-1:0] blink_len;

    out_item_t display_q [$];
    out_item_t fixed_view;
    logic      fixed_pending = 1'b0;
    int        err_count = 0;
    int        in_idle_pct = 31;
    int        out_idle_pct = 31;
    int        ready_hold = 0;

    function automatic int day_secs(input bcd_time_t t);
        return int'(t[5]) * 36000 + int'(t[4]) * 3600 + int'(t[3]) * 600
             + int'(t[2]) * 60 + int'(t[1]) * 10 + int'(t[0]);
    endfunction

    function automatic bcd_time_t secs_bcd(input int s);
        bcd_time_t t;
        int sc;
        int mn;
        int hr;
        sc = s % 60;
        mn = (s / 60) % 60;
        hr = s / 3600;
        t[0] = digit_t'(sc % 10);
        t[1] = digit_t'(sc / 10);
        t[2] = digit_t'(mn % 10);
        t[3] = digit_t'(mn / 10);
        t[4] = digit_t'(hr % 10);
        t[5] = digit_t'(hr / 10);
        return t;
    endfunction

    // Steps one two-digit alarm field by one, wrapping at 60 or 24.
    function automatic bcd_time_t step_field(input bcd_time_t t, input field_t f,
                                             input logic up);
        int idx;
        int span;
        int v;
        idx = 2 * (int'(f) - 1);
        span = (f == FIELD_HR) ? 24 : 60;
        v = int'(t[idx + 1]) * 10 + int'(t[idx]);
        v = up ? (v + 1) % span : (v + span - 1) % span;
        t[idx] = digit_t'(v % 10);
        t[idx + 1] = digit_t'(v / 10);
        return t;
    endfunction

    function automatic out_item_t poll_step(input in_item_t it);
        bcd_time_t shown;
        out_item_t r;
        if (it.second_tick)
        begin
            clk_time = secs_bcd((day_secs(clk_time) + 1) % DAY_SECS);
            if (clk_time == alm_time)
                alm_latched = 1'b1;
        end
        if (alm_latched)
        begin
            blink_cnt = blink_cnt + 1'b1;
            if (blink_cnt == blink_len)
            begin
                blink_cnt = '0;
                blink_ph = ~blink_ph;
                led_on = blink_ph;
            end
            // Shutoff leaves the blink phase and count where they are.
            if (it.force_req >= thr)
            begin
                alm_latched = 1'b0;
                led_on = 1'b0;
            end
        end
        if (!held)
        begin
            if (it.keys == KEY_MODE)
            begin
                held = 1'b1;
                setting = ~setting;
                if (setting)
                    fsel = FIELD_SEC;
            end
            else if (it.keys == KEY_FIELD)
            begin
                held = 1'b1;
                case (fsel)
                    FIELD_SEC: fsel = FIELD_MIN;
                    FIELD_MIN: fsel = FIELD_HR;
                    FIELD_HR:  fsel = FIELD_SEC;
                    default:   fsel = fsel;
                endcase
            end
            else if ((it.keys == KEY_DOWN || it.keys == KEY_UP) && setting)
            begin
                held = 1'b1;
                if (fsel != FIELD_NONE)
                    alm_time = step_field(alm_time, fsel, it.keys == KEY_UP);
            end
        end
        if (it.keys != KEY_MODE && it.keys != KEY_FIELD && it.keys != KEY_DOWN
            && it.keys != KEY_UP)
            held = 1'b0;
        shown = setting ? alm_time : clk_time;
        r.seg_sec_ones = SEG_TABLE[shown[0]];
        r.seg_sec_tens = SEG_TABLE[shown[1]];
        r.seg_min_ones = SEG_TABLE[shown[2]];
        r.seg_min_tens = SEG_TABLE[shown[3]];
        r.seg_hr_ones  = SEG_TABLE[shown[4]];
        r.seg_hr_tens  = SEG_TABLE[shown[5]];
        r.led          = led_on;
        r.alarm_on     = alm_latched;
        return r;
    endfunction

    // Mostly below the threshold, now and then exactly on it or anywhere.
    function automatic logic [ThrW-1:0] pick_force();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return thr;
        if (r < 12 || thr == '0)
            return ThrW'($urandom_range(1023));
        return ThrW'($urandom_range(int'(thr) - 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_step(input in_item_t it);
        out_item_t view;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.second_tick = it.second_tick;
        in_ch.keys = it.keys;
        in_ch.force_req = it.force_req;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        view = poll_step(it);
        if (fixed_pending)
        begin
            view = fixed_view;
            fixed_pending = 1'b0;
        end
        display_q.push_back(view);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
        // Two register stages; let them empty completely.
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.wdata = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_SHUTOFF: thr = val[ThrW-1:0];
            REG_BLINK:   blink_len = val;
            default:     ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // A press followed by a release, which is sometimes a chord.
    task automatic press_key(input logic [KeyW-1:0] k);
        logic [KeyW-1:0] rel;
        send_step(in_item_t'{1'b0, k, pick_force()});
        rel = KEYS_IDLE;
        if ($urandom_range(99) < 30)
        begin
            do
                rel = KeyW'($urandom_range(15));
            while (rel == KEY_MODE || rel == KEY_FIELD || rel == KEY_DOWN || rel == KEY_UP);
        end
        send_step(in_item_t'{1'b0, rel, pick_force()});
    endtask

    // Keys the alarm to lead seconds past the current clock time, taking the
    // shorter way round on each field. No ticks are sent meanwhile.
    task automatic aim_alarm(input int lead);
        int goal;
        int goal_f [3];
        int span;
        int cur;
        int d;
        goal = (day_secs(clk_time) + lead) % DAY_SECS;
        goal_f[0] = goal % 60;
        goal_f[1] = (goal / 60) % 60;
        goal_f[2] = goal / 3600;
        send_step(in_item_t'{1'b0, KEYS_IDLE, pick_force()});
        if (setting)
            press_key(KEY_MODE);
        press_key(KEY_MODE);
        for (int i = 0; i < 3; i++)
        begin
            span = (i == 2) ? 24 : 60;
            cur = int'(alm_time[2 * i + 1]) * 10 + int'(alm_time[2 * i]);
            d = (goal_f[i] - cur + span) % span;
            if (d <= span / 2)
                repeat (d) press_key(KEY_UP);
            else
                repeat (span - d) press_key(KEY_DOWN);
            if (i < 2)
                press_key(KEY_FIELD);
        end
        press_key(KEY_MODE);
    endtask

    task automatic poll_noise(input int n);
        in_item_t it;
        repeat (n)
        begin
            it.second_tick = 1'($urandom_range(1));
            it.keys = ($urandom_range(99) < 85) ? KEYS_IDLE : KeyW'($urandom_range(15));
            it.force_req = pick_force();
            send_step(it);
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            sink_ready = 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
        begin
            sink_ready = ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.seg_sec_ones, out_ch.seg_sec_tens, out_ch.seg_min_ones,
                    out_ch.seg_min_tens, out_ch.seg_hr_ones, out_ch.seg_hr_tens,
                    out_ch.led, out_ch.alarm_on};
            if (display_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: result with none expected: %p", $time, got);
            end
            else
            begin
                want = display_q.pop_front();
                if (got.seg_sec_ones !== want.seg_sec_ones
                    || got.seg_sec_tens !== want.seg_sec_tens
                    || got.seg_min_ones !== want.seg_min_ones
                    || got.seg_min_tens !== want.seg_min_tens
                    || got.seg_hr_ones !== want.seg_hr_ones
                    || got.seg_hr_tens !== want.seg_hr_tens
                    || got.led !== want.led
                    || got.alarm_on !== want.alarm_on)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: mismatch, expected %p, got %p", $time, want, got);
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.second_tick = 1'b0;
        in_ch.keys = KEYS_IDLE;
        in_ch.force_req = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SHUTOFF;
        cfg_ch.wdata = '0;

        clk_time = CLOCK_RESET;
        alm_time = ALARM_RESET;
        setting = 1'b0;
        fsel = FIELD_SEC;
        alm_latched = 1'b0;
        blink_ph = 1'b0;
        led_on = 1'b0;
        blink_cnt = '0;
        held = 1'b0;
        thr = THR_RESET;
        blink_len = PERIOD_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            fixed_pending = DIRECTED_ROWS[i].typed;
            fixed_view = DIRECTED_ROWS[i].view;
            send_step(DIRECTED_ROWS[i].step);
        end

        // Blink periods only grow from one setting to the next, so the count
        // left over from before never runs past the new period.
        for (int s = 0; s < 6; s++)
        begin
            wait_idle();
            case (s)
                0:
                begin
                    write_reg(REG_SHUTOFF, 16'd1023);
                    write_reg(REG_BLINK, 16'd1);
                end
                1:
                begin
                    write_reg(REG_SHUTOFF, 16'd0);
                    write_reg(REG_BLINK, 16'd2);
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_idle_pct = 0;
                    write_reg(REG_SHUTOFF, CfgW'($urandom_range(1, 1022)));
                    write_reg(REG_BLINK, CfgW'($urandom_range(3, 6)));
                end
                3:
                begin
                    in_idle_pct = 31;
                    out_idle_pct = 31;
                    write_reg(REG_SHUTOFF, CfgW'($urandom_range(1, 1022)));
                    write_reg(REG_BLINK, CfgW'($urandom_range(7, 12)));
                end
                4:
                begin
                    write_reg(REG_UNUSED, CfgW'($urandom_range(65535)));
                    write_reg(REG_SHUTOFF, CfgW'($urandom_range(1, 1022)));
                    write_reg(REG_BLINK, CfgW'($urandom_range(13, 20)));
                end
                default:
                begin
                    write_reg(REG_SHUTOFF, CfgW'($urandom_range(1, 1022)));
                    write_reg(REG_BLINK, CfgW'($urandom_range(21, 40)));
                end
            endcase
            for (int r = 0; r < 3; r++)
            begin
                aim_alarm($urandom_range(2, 20));
                if (s == 3)
                begin
                    // Stall the output while the input keeps pushing.
                    in_idle_pct = 0;
                    in_ch.valid = 1'b0;
                    @(posedge clk);
                    ready_hold = 60;
                    @(negedge clk);
                end
                poll_noise($urandom_range(40, 70));
                in_idle_pct = (s == 2) ? 0 : 31;
            end
        end

        // Ticks on every step with the alarm held on and the longest blink
        // period, then full force to release it.
        wait_idle();
        in_idle_pct = 31;
        out_idle_pct = 31;
        write_reg(REG_SHUTOFF, 16'd1023);
        write_reg(REG_BLINK, 16'hFFFF);
        aim_alarm(3);
        for (int i = 0; i < FINAL_STEPS; i++)
        begin
            send_step(in_item_t'{1'b1,
                                 ($urandom_range(99) < 3) ? KeyW'($urandom_range(15))
                                                          : KEYS_IDLE,
                                 (i >= FINAL_STEPS - 5) ? 10'd1023
                                                        : ThrW'($urandom_range(1022))});
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/acc_pkg.sv
hw/rtl/acc_if.sv
hw/rtl/acc_in_stage.sv
hw/rtl/acc_step.sv
hw/rtl/acc_out_stage.sv
hw/rtl/bcd_alarm_clock_controller.sv
hw/rtl/acc_checker.sv
sim/bcd_alarm_clock_controller_tb.sv
